// ===== hw/rtl/lrupr_pkg.sv =====
package lrupr_pkg;

	// Default geometry of the tracker.
	localparam int FRAMES_DEF    = 4;
	localparam int PAGE_BITS_DEF = 16;

	// Width of the saturating fault total.
	localparam int COUNT_W = 32;

endpackage

// ===== hw/rtl/lrupr_cell.sv =====
module lrupr_cell import lrupr_pkg::*; #(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	parameter int IDX       = 0,
	localparam int IW       = $clog2(FRAMES)
) (
	input  logic clk,
	input  logic arst_n,
	// Scan token from the previous cell and to the next one.
	input  logic [1+PAGE_BITS+1+IW+IW+1+IW+IW+IW+PAGE_BITS-1:0] tok_in,
	output logic [1+PAGE_BITS+1+IW+IW+1+IW+IW+IW+PAGE_BITS-1:0] tok_out,
	// Update broadcast from the decision logic.
	input  logic [1+IW+1+1+PAGE_BITS+IW-1:0] upd_in
);

	typedef struct packed {
		logic                 vld;
		logic [PAGE_BITS-1:0] page;
		logic                 hit;
		logic [IW-1:0]        hit_idx;
		logic [IW-1:0]        hit_rank;
		logic                 empty;
		logic [IW-1:0]        empty_idx;
		logic [IW-1:0]        max_rank;
		logic [IW-1:0]        max_idx;
		logic [PAGE_BITS-1:0] max_page;
	} scan_t;

	typedef struct packed {
		logic                 en;
		logic [IW-1:0]        idx;
		logic                 age_all;
		logic                 write;
		logic [PAGE_BITS-1:0] page;
		logic [IW-1:0]        limit;
	} upd_t;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	scan_t                tin;
	scan_t                tnext;
	scan_t                tok_q;
	upd_t                 upd;
	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [IW-1:0]        rank_q;

	assign tin     = scan_t'(tok_in);
	assign upd     = upd_t'(upd_in);
	assign tok_out = tok_q;

	// Merge this frame's entry into the passing token.
	always_comb begin
		tnext = tin;
		if (valid_q && (page_q == tin.page) && !tin.hit) begin
			tnext.hit      = 1'b1;
			tnext.hit_idx  = MY_IDX;
			tnext.hit_rank = rank_q;
		end
		if (!valid_q && !tin.empty) begin
			tnext.empty     = 1'b1;
			tnext.empty_idx = MY_IDX;
		end
		if ((IDX == 0) || (rank_q > tin.max_rank)) begin
			tnext.max_rank = rank_q;
			tnext.max_idx  = MY_IDX;
			tnext.max_page = page_q;
		end
	end

	// Token register towards the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tnext;
		end
	end

	// Frame state: valid bit and recency rank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.en) begin
			if (upd.idx == MY_IDX) begin
				rank_q <= '0;
				if (upd.write) begin
					valid_q <= 1'b1;
				end
			end else if (valid_q && (upd.age_all || (rank_q < upd.limit))) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	// Resident page number; meaningful only while the frame is valid.
	always_ff @(posedge clk) begin
		if (upd.en && (upd.idx == MY_IDX) && upd.write) begin
			page_q <= upd.page;
		end
	end

endmodule

// ===== hw/rtl/lru_page_replacement_core.sv =====
// Fully associative LRU page-frame tracker. Each page reference word on the input
// channel yields one result word: hit or fault, the frame that now holds the page,
// the page evicted (zero if none) and the saturating fault total. The frames sit
// in a row of cells; a scan token walks the row one cell per cycle, collecting the
// hit, the lowest empty frame and the oldest frame, and the decision is then sent
// to all cells at once. The completed scan waits in a holding register until the
// output register is free, and the result is then loaded there; a new reference is
// accepted only after the previous result has been loaded, so one reference is in
// flight at a time. A waiting result holds the final step, not the scan.
module lru_page_replacement_core import lrupr_pkg::*; #(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	localparam int IW       = $clog2(FRAMES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PAGE_BITS-1:0] page,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 fault,
	output logic [IW-1:0]        frame,
	output logic                 evicted_valid,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [COUNT_W-1:0]   fault_count
);

	typedef struct packed {
		logic                 vld;
		logic [PAGE_BITS-1:0] page;
		logic                 hit;
		logic [IW-1:0]        hit_idx;
		logic [IW-1:0]        hit_rank;
		logic                 empty;
		logic [IW-1:0]        empty_idx;
		logic [IW-1:0]        max_rank;
		logic [IW-1:0]        max_idx;
		logic [PAGE_BITS-1:0] max_page;
	} scan_t;

	typedef struct packed {
		logic                 en;
		logic [IW-1:0]        idx;
		logic                 age_all;
		logic                 write;
		logic [PAGE_BITS-1:0] page;
		logic [IW-1:0]        limit;
	} upd_t;

	scan_t                tok [FRAMES+1];
	scan_t                pend_q;
	logic                 pend_valid_q;
	logic                 busy_q;
	logic                 accept;
	logic                 finish;
	upd_t                 upd;
	logic                 d_fault;
	logic                 d_evict;
	logic [IW-1:0]        d_use;
	logic [COUNT_W-1:0]   total_q;
	logic [COUNT_W-1:0]   total_next;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;

	// A fresh token enters the first cell when a word is accepted.
	always_comb begin
		tok[0]      = '0;
		tok[0].vld  = accept;
		tok[0].page = page;
	end

	// Row of frame cells.
	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		lrupr_cell #(
			.FRAMES    (FRAMES),
			.PAGE_BITS (PAGE_BITS),
			.IDX       (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.upd_in  (upd)
		);
	end

	// Decision from the completed scan.
	always_comb begin
		d_fault = !pend_q.hit;
		d_evict = d_fault && !pend_q.empty;
		if (pend_q.hit) begin
			d_use = pend_q.hit_idx;
		end else if (pend_q.empty) begin
			d_use = pend_q.empty_idx;
		end else begin
			d_use = pend_q.max_idx;
		end
		if (d_fault && (total_q != '1)) begin
			total_next = total_q + 1'b1;
		end else begin
			total_next = total_q;
		end
	end

	// The result is committed once the output register is free.
	assign finish = pend_valid_q && (!out_valid || !out_stall);

	always_comb begin
		upd         = '0;
		upd.en      = finish;
		upd.idx     = d_use;
		upd.age_all = d_fault;
		upd.write   = d_fault;
		upd.page    = pend_q.page;
		upd.limit   = pend_q.hit_rank;
	end

	// Control: busy flag, completed-scan holding register, fault total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			total_q      <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (tok[FRAMES].vld) begin
				pend_valid_q <= 1'b1;
			end else if (finish) begin
				pend_valid_q <= 1'b0;
			end
			if (finish) begin
				total_q <= total_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok[FRAMES].vld) begin
			pend_q <= tok[FRAMES];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (finish) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			fault         <= d_fault;
			frame         <= d_use;
			evicted_valid <= d_evict;
			evicted_page  <= d_evict ? pend_q.max_page : '0;
			fault_count   <= total_next;
		end
	end

endmodule

// ===== hw/rtl/lrupr_checker.sv =====
module lrupr_checker import lrupr_pkg::*; #(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	localparam int IW       = $clog2(FRAMES)
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [PAGE_BITS-1:0] page,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 fault,
	input logic [IW-1:0]        frame,
	input logic                 evicted_valid,
	input logic [PAGE_BITS-1:0] evicted_page,
	input logic [COUNT_W-1:0]   fault_count
);

	// A stalled result word keeps its frame and fault total.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame) && $stable(fault_count))
		else $error("stalled result word changed");

	// A hit never evicts a page.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fault |-> !evicted_valid)
		else $error("eviction reported on a hit");

	// With no eviction the evicted page reads as zero.
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_page == '0)
		else $error("evicted page not zero without eviction");

	// A reference occupies the block: the next cycle refuses input.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a reference is in flight");

	// A fault word always reports a non-zero total.
	a_fault_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> fault_count != '0)
		else $error("fault reported with zero total");

endmodule

bind lru_page_replacement_core lrupr_checker #(
	.FRAMES    (FRAMES),
	.PAGE_BITS (PAGE_BITS)
) u_lrupr_checker (.*);
